// ===== hw/rtl/iyst_pkg.sv =====
// Shared constants, register codes and small lookup functions for the
// yaw and slope tracker. No dependencies.
`default_nettype none

package iyst_pkg;

    // Default parameter values
    localparam int QUAT_FRAC_BITS_DEF   = 30;
    localparam int ANGLE_ITERATIONS_DEF = 16;

    // Field and state widths
    localparam int CNT_W  = 17;
    localparam int TILT_W = 48;

    localparam logic [CNT_W-1:0]   CNT_MAX        = 17'h1FFFF;
    localparam logic [TILT_W-1:0]  TILT_MAX       = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [35:0] TILT_SCALE     = 36'sd1000;
    localparam logic [29:0]        CUBE_LIMIT_Q16 = 30'(1625 * 65536);
    localparam logic signed [35:0] PI_Q30         = 36'sd3373259426;
    localparam logic signed [35:0] YAW_LIMIT      = 36'sd25736;

    // Register reset values
    localparam logic [30:0]       STILL_EPS_W_RST     = 31'd214748;
    localparam logic [30:0]       STILL_EPS_V_RST     = 31'd214748;
    localparam logic [15:0]       CALIB_TICKS_RST     = 16'd100;
    localparam logic [TILT_W-1:0] SLOPE_THRESHOLD_RST = 48'd1310720;
    localparam logic [15:0]       SLOPE_TICKS_RST     = 16'd20;
    localparam logic [TILT_W-1:0] RISE_LIMIT_RST      = 48'd13107;
    localparam logic [TILT_W-1:0] FALL_LIMIT_RST      = 48'd327680;

    // Register map, one 64-bit word each
    typedef enum logic [2:0] {
        REG_STILL_EPS_W     = 3'd0,
        REG_STILL_EPS_V     = 3'd1,
        REG_CALIB_TICKS     = 3'd2,
        REG_SLOPE_THRESHOLD = 3'd3,
        REG_SLOPE_TICKS     = 3'd4,
        REG_RISE_LIMIT      = 3'd5,
        REG_FALL_LIMIT      = 3'd6
    } reg_index_t;

    // Sign of term j of component k in a * conj(b); b index is k ^ j
    function automatic logic conj_negative(input logic [1:0] k, input logic [1:0] j);
        logic [15:0] mask;
        mask = 16'h3950;
        return mask[{k, j}];
    endfunction

    // atan(2^-i) in Q30
    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/imu_yaw_and_slope_tracker_top.sv =====
// Yaw and slope tracker: calibration, relative orientation, CORDIC angles,
// tilt metric, slew filter and slope debounce. Depends on iyst_pkg.
//
//  channel   dir  handshake         payload
//  s_*       in   tvalid/tready     tdata: quat w,x,y,z; tuser: mode
//  m_*       out  tvalid/tready     tdata: calibrated,yaw,slope,orient; tuser: angles_valid
//  apb       in   psel/penable      64-bit registers at 8*index, pready always high
//
// One request at a time through a shared 36x36 multiply-accumulate, one CORDIC
// stage and one square-root step, all under one sequencer.
// A capture goes straight to the output. A calibrated tick runs two 31-step
// square roots and three CORDIC runs; an uncalibrated tick runs neither.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next request is worked on while it waits.
// Reset zeroes state, sets ref/prev to identity, loads register defaults; no clearing pass.
`default_nettype none

module imu_yaw_and_slope_tracker_top
    import iyst_pkg::*;
#(
    parameter int QUAT_FRAC_BITS   = QUAT_FRAC_BITS_DEF,
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // quat_w[31:0], quat_x, quat_y, quat_z
    input  wire logic         s_tuser,   // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [151:0]      m_tdata,   // calibrated, yaw[15:0], slope_detected,
                                         // orient_w..z (32 each), zero pad
    output logic              m_tuser,   // angles_valid
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    localparam int SHIFT_A = 30 - QUAT_FRAC_BITS;
    localparam int IT_W    = $clog2(ANGLE_ITERATIONS);
    localparam logic signed [32:0] ONE_Q     = 33'(64'd1 << QUAT_FRAC_BITS);
    localparam logic signed [32:0] NEG_ONE_Q = -ONE_Q;
    localparam logic signed [71:0] HALF_Q    = 72'(64'd1 << (QUAT_FRAC_BITS - 1));
    localparam logic signed [35:0] ONE_A     = 36'sd1073741824;

    typedef enum logic [4:0] {
        S_IDLE, S_MC_MUL, S_MC_ACC, S_MC_RND, S_STILL, S_CALCHK,
        S_PR_MUL, S_PR_ACC, S_PR_RND, S_CD_INIT, S_CD_STEP, S_CD_DONE,
        S_SQ_MUL, S_SQ_SUB, S_SQRT, S_TL_MUL, S_TL_ACC, S_TL_RND,
        S_FILT, S_FILT_APPLY, S_SLOPE, S_OUT
    } state_t;

    typedef enum logic [1:0] {SEL_YAW, SEL_ROLL, SEL_PITCH} angle_sel_t;

    // Configuration registers
    logic [30:0]       still_eps_w_reg, still_eps_v_reg;
    logic [15:0]       calib_ticks_reg, slope_ticks_reg;
    logic [TILT_W-1:0] slope_threshold_reg, rise_limit_reg, fall_limit_reg;

    // Sequencer and datapath registers
    state_t            state_reg;
    angle_sel_t        asel_reg;
    logic [1:0]        k_reg, j_reg;
    logic [2:0]        tp_reg;
    logic [IT_W-1:0]   it_reg;
    logic [4:0]        sk_reg;
    logic signed [31:0] q_reg [4];
    logic signed [31:0] ref_reg [4];
    logic signed [31:0] prev_reg [4];
    logic signed [31:0] o_reg [4];
    logic signed [71:0] prod_reg, acc_reg;
    logic              pneg_reg, pshl_reg, pfirst_reg;
    logic signed [35:0] num_reg, den_reg, rarg_reg, parg_reg;
    logic signed [39:0] cx_reg, cy_reg;
    logic signed [35:0] cz_reg;
    logic signed [15:0] yaw_reg;
    logic signed [35:0] roll_reg;
    logic signed [31:0] s_reg;
    logic [61:0]       sv_reg;
    logic [62:0]       sr_reg;
    logic [34:0]       t_reg;
    logic [26:0]       ta_reg;
    logic [37:0]       sq_reg;
    logic [TILT_W-1:0] tilt_reg, filt_reg, fstep_reg;
    logic              fup_reg;
    logic [CNT_W-1:0]  still_cnt_reg, slope_cnt_reg;
    logic              calib_reg, av_reg;

    // Output register
    logic              m_valid_reg, out_av_reg, out_cal_reg, out_slope_reg;
    logic signed [15:0] out_yaw_reg;
    logic signed [31:0] out_o_reg [4];

    // Combinational helpers
    logic signed [31:0] qin [4];
    logic signed [31:0] a_val [4];
    logic signed [35:0] opa, opb;
    logic              op_neg, op_shl, op_first;
    logic [1:0]        pa_idx, pb_idx;
    logic signed [71:0] term, q_sum, q_shift, pr_sum;
    logic signed [31:0] q_rnd;
    logic signed [35:0] pr_rnd;
    logic signed [39:0] cin_x, cin_y, cd_dx, cd_dy;
    logic signed [35:0] cd_atan, yaw_full;
    logic signed [15:0] yaw_clamped;
    logic signed [31:0] s_next;
    logic [62:0]       sq_bit, sq_trial;
    logic [71:0]       acc_u, acc_rh;
    logic [29:0]       a_full;
    logic [55:0]       cube_full;
    logic              still;
    logic signed [32:0] dw_dev;
    logic signed [35:0] rarg_pick;
    logic              in_acc, out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);
    assign pready   = 1'b1;

    // Sign-extend and clamp the incoming sample
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if ($signed({s_tdata[32*i+31], s_tdata[32*i +: 32]}) > ONE_Q)
                qin[i] = ONE_Q[31:0];
            else if ($signed({s_tdata[32*i+31], s_tdata[32*i +: 32]}) < NEG_ONE_Q)
                qin[i] = NEG_ONE_Q[31:0];
            else
                qin[i] = s_tdata[32*i +: 32];
        end
    end

    // Relative quaternion scaled to Q30
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            a_val[i] = 32'(o_reg[i] <<< SHIFT_A);
    end

    // Pick operand pairs for the angle products
    always_comb
    begin
        pa_idx = 2'd0;
        pb_idx = 2'd0;
        case ({k_reg, j_reg[0]})
            3'b000: begin pa_idx = 2'd1; pb_idx = 2'd2; end
            3'b001: begin pa_idx = 2'd3; pb_idx = 2'd0; end
            3'b010: begin pa_idx = 2'd2; pb_idx = 2'd2; end
            3'b011: begin pa_idx = 2'd3; pb_idx = 2'd3; end
            3'b100: begin pa_idx = 2'd1; pb_idx = 2'd3; end
            3'b101: begin pa_idx = 2'd2; pb_idx = 2'd0; end
            3'b110: begin pa_idx = 2'd1; pb_idx = 2'd0; end
            default: begin pa_idx = 2'd2; pb_idx = 2'd3; end
        endcase
    end

    // Multiplier operand select
    always_comb
    begin
        opa      = '0;
        opb      = '0;
        op_neg   = 1'b0;
        op_shl   = 1'b0;
        op_first = 1'b0;
        case (state_reg)
            S_MC_MUL:
            begin
                opa      = 36'(q_reg[j_reg]);
                opb      = calib_reg ? 36'(ref_reg[k_reg ^ j_reg])
                                     : 36'(prev_reg[k_reg ^ j_reg]);
                op_neg   = conj_negative(k_reg, j_reg);
                op_first = (j_reg == 2'd0);
            end
            S_PR_MUL:
            begin
                opa      = 36'(a_val[pa_idx]);
                opb      = 36'(a_val[pb_idx]);
                op_neg   = (k_reg == 2'd2) && j_reg[0];
                op_first = (j_reg == 2'd0);
            end
            S_SQ_MUL:
            begin
                opa      = 36'(s_reg);
                opb      = 36'(s_reg);
                op_first = 1'b1;
            end
            S_TL_MUL:
            begin
                case (tp_reg)
                    3'd0: begin opa = roll_reg; opb = roll_reg; op_first = 1'b1; end
                    3'd1: begin opa = cz_reg; opb = cz_reg; end
                    3'd2: begin opa = {1'b0, t_reg}; opb = TILT_SCALE; op_first = 1'b1; end
                    3'd3: begin opa = {9'd0, ta_reg}; opb = {9'd0, ta_reg}; op_first = 1'b1; end
                    3'd4:
                    begin
                        opa      = {17'd0, sq_reg[37:19]};
                        opb      = {9'd0, ta_reg};
                        op_shl   = 1'b1;
                        op_first = 1'b1;
                    end
                    default: begin opa = {17'd0, sq_reg[18:0]}; opb = {9'd0, ta_reg}; end
                endcase
            end
            default: ;
        endcase
    end

    // Accumulate term and rounding of the accumulator
    always_comb
    begin
        term    = pshl_reg ? (prod_reg <<< 19) : prod_reg;
        term    = pneg_reg ? -term : term;
        q_sum   = acc_reg + HALF_Q;
        q_shift = q_sum >>> QUAT_FRAC_BITS;
        if (q_shift > 72'(ONE_Q))
            q_rnd = ONE_Q[31:0];
        else if (q_shift < 72'(NEG_ONE_Q))
            q_rnd = NEG_ONE_Q[31:0];
        else
            q_rnd = q_shift[31:0];
        pr_sum  = (acc_reg + 72'sd268435456) >>> 29;
        pr_rnd  = pr_sum[35:0];
        acc_u   = acc_reg;
        acc_rh  = acc_u + 72'd32768;
        a_full  = acc_rh[45:16];
        cube_full = acc_rh[71:16];
    end

    // Stillness test on the difference quaternion held in o_reg
    always_comb
    begin
        dw_dev = {o_reg[0][31], o_reg[0]} - ONE_Q;
        if (dw_dev < 0)
            dw_dev = -dw_dev;
        still = (dw_dev < $signed({2'b00, still_eps_w_reg}));
        for (int i = 1; i < 4; i++)
        begin
            if ((o_reg[i] < 0 ? -{o_reg[i][31], o_reg[i]} : {o_reg[i][31], o_reg[i]})
                >= $signed({2'b00, still_eps_v_reg}))
                still = 1'b0;
        end
    end

    // CORDIC start values, step and angle rounding
    always_comb
    begin
        if (asel_reg == SEL_YAW)
        begin
            cin_y = 40'(num_reg);
            cin_x = 40'(den_reg);
        end
        else
        begin
            cin_y = 40'(s_reg);
            cin_x = {9'd0, sr_reg[30:0]};
        end
        cd_dx   = cy_reg >>> it_reg;
        cd_dy   = cx_reg >>> it_reg;
        cd_atan = $signed({6'd0, atan_entry(5'(it_reg))});
        yaw_full = (cz_reg + 36'sd65536) >>> 17;
        if (yaw_full > YAW_LIMIT)
            yaw_clamped = YAW_LIMIT[15:0];
        else if (yaw_full < -YAW_LIMIT)
            yaw_clamped = 16'(-YAW_LIMIT);
        else
            yaw_clamped = yaw_full[15:0];
        rarg_pick = (asel_reg == SEL_YAW) ? rarg_reg : parg_reg;
        if (rarg_pick > ONE_A)
            s_next = ONE_A[31:0];
        else if (rarg_pick < -ONE_A)
            s_next = 32'(-ONE_A);
        else
            s_next = rarg_pick[31:0];
        sq_bit   = 63'd1 << {sk_reg, 1'b0};
        sq_trial = sr_reg + sq_bit;
    end

    // Sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            asel_reg      <= SEL_YAW;
            k_reg         <= '0;
            j_reg         <= '0;
            tp_reg        <= '0;
            it_reg        <= '0;
            sk_reg        <= '0;
            for (int i = 0; i < 4; i++)
            begin
                q_reg[i]     <= '0;
                ref_reg[i]   <= (i == 0) ? ONE_Q[31:0] : '0;
                prev_reg[i]  <= (i == 0) ? ONE_Q[31:0] : '0;
                o_reg[i]     <= '0;
                out_o_reg[i] <= '0;
            end
            prod_reg      <= '0;
            acc_reg       <= '0;
            pneg_reg      <= 1'b0;
            pshl_reg      <= 1'b0;
            pfirst_reg    <= 1'b0;
            num_reg       <= '0;
            den_reg       <= '0;
            rarg_reg      <= '0;
            parg_reg      <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            yaw_reg       <= '0;
            roll_reg      <= '0;
            s_reg         <= '0;
            sv_reg        <= '0;
            sr_reg        <= '0;
            t_reg         <= '0;
            ta_reg        <= '0;
            sq_reg        <= '0;
            tilt_reg      <= '0;
            filt_reg      <= '0;
            fstep_reg     <= '0;
            fup_reg       <= 1'b0;
            still_cnt_reg <= '0;
            slope_cnt_reg <= '0;
            calib_reg     <= 1'b0;
            av_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_av_reg    <= 1'b0;
            out_cal_reg   <= 1'b0;
            out_slope_reg <= 1'b0;
            out_yaw_reg   <= '0;
        end
        else
        begin
            // Load a finished result, drop it once taken
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            // Multiplier stage
            prod_reg   <= 72'(opa * opb);
            pneg_reg   <= op_neg;
            pshl_reg   <= op_shl;
            pfirst_reg <= op_first;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        av_reg <= 1'b0;
                        k_reg  <= '0;
                        j_reg  <= '0;
                        for (int i = 0; i < 4; i++)
                            q_reg[i] <= qin[i];
                        if (s_tuser)
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                ref_reg[i] <= qin[i];
                                o_reg[i]   <= (i == 0) ? ONE_Q[31:0] : '0;
                            end
                            calib_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_MC_MUL;
                    end
                end
                S_MC_MUL:
                    state_reg <= S_MC_ACC;
                S_MC_ACC:
                begin
                    acc_reg <= pfirst_reg ? term : acc_reg + term;
                    if (j_reg == 2'd3)
                        state_reg <= S_MC_RND;
                    else
                    begin
                        j_reg     <= j_reg + 2'd1;
                        state_reg <= S_MC_MUL;
                    end
                end
                S_MC_RND:
                begin
                    o_reg[k_reg] <= q_rnd;
                    j_reg        <= '0;
                    if (k_reg == 2'd3)
                    begin
                        k_reg     <= '0;
                        state_reg <= calib_reg ? S_PR_MUL : S_STILL;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_MC_MUL;
                    end
                end
                S_STILL:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        prev_reg[i] <= q_reg[i];
                        o_reg[i]    <= q_reg[i];
                    end
                    if (!still)
                        still_cnt_reg <= '0;
                    else if (still_cnt_reg != CNT_MAX)
                        still_cnt_reg <= still_cnt_reg + 17'd1;
                    state_reg <= S_CALCHK;
                end
                S_CALCHK:
                begin
                    if (still_cnt_reg > {1'b0, calib_ticks_reg})
                    begin
                        calib_reg <= 1'b1;
                        for (int i = 0; i < 4; i++)
                            ref_reg[i] <= q_reg[i];
                    end
                    state_reg <= S_OUT;
                end
                S_PR_MUL:
                    state_reg <= S_PR_ACC;
                S_PR_ACC:
                begin
                    acc_reg <= pfirst_reg ? term : acc_reg + term;
                    if (j_reg[0])
                        state_reg <= S_PR_RND;
                    else
                    begin
                        j_reg     <= j_reg + 2'd1;
                        state_reg <= S_PR_MUL;
                    end
                end
                S_PR_RND:
                begin
                    case (k_reg)
                        2'd0: num_reg  <= pr_rnd;
                        2'd1: den_reg  <= ONE_A - pr_rnd;
                        2'd2: rarg_reg <= pr_rnd;
                        default: parg_reg <= pr_rnd;
                    endcase
                    j_reg <= '0;
                    if (k_reg == 2'd3)
                    begin
                        asel_reg  <= SEL_YAW;
                        state_reg <= S_CD_INIT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_PR_MUL;
                    end
                end
                S_CD_INIT:
                begin
                    it_reg <= '0;
                    if (cin_x == 0 && cin_y == 0)
                    begin
                        cz_reg    <= '0;
                        state_reg <= S_CD_DONE;
                    end
                    else
                    begin
                        if (cin_x < 0)
                        begin
                            cz_reg <= (cin_y >= 0) ? PI_Q30 : -PI_Q30;
                            cx_reg <= -cin_x;
                            cy_reg <= -cin_y;
                        end
                        else
                        begin
                            cz_reg <= '0;
                            cx_reg <= cin_x;
                            cy_reg <= cin_y;
                        end
                        state_reg <= S_CD_STEP;
                    end
                end
                S_CD_STEP:
                begin
                    if (cy_reg > 0)
                    begin
                        cx_reg <= cx_reg + cd_dx;
                        cy_reg <= cy_reg - cd_dy;
                        cz_reg <= cz_reg + cd_atan;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - cd_dx;
                        cy_reg <= cy_reg + cd_dy;
                        cz_reg <= cz_reg - cd_atan;
                    end
                    if (it_reg == IT_W'(ANGLE_ITERATIONS - 1))
                        state_reg <= S_CD_DONE;
                    else
                        it_reg <= it_reg + 1'b1;
                end
                S_CD_DONE:
                begin
                    case (asel_reg)
                        SEL_YAW:
                        begin
                            yaw_reg   <= yaw_clamped;
                            s_reg     <= s_next;
                            asel_reg  <= SEL_ROLL;
                            state_reg <= S_SQ_MUL;
                        end
                        SEL_ROLL:
                        begin
                            roll_reg  <= cz_reg;
                            s_reg     <= s_next;
                            asel_reg  <= SEL_PITCH;
                            state_reg <= S_SQ_MUL;
                        end
                        default:
                        begin
                            // Pitch stays in cz_reg for the tilt products
                            tp_reg    <= '0;
                            state_reg <= S_TL_MUL;
                        end
                    endcase
                end
                S_SQ_MUL:
                    state_reg <= S_SQ_SUB;
                S_SQ_SUB:
                begin
                    sv_reg    <= 62'(64'd1 << 60) - prod_reg[61:0];
                    sr_reg    <= '0;
                    sk_reg    <= 5'd30;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if ({1'b0, sv_reg} >= sq_trial)
                    begin
                        sv_reg <= 62'({1'b0, sv_reg} - sq_trial);
                        sr_reg <= (sr_reg >> 1) + sq_bit;
                    end
                    else
                        sr_reg <= sr_reg >> 1;
                    if (sk_reg == 5'd0)
                        state_reg <= S_CD_INIT;
                    else
                        sk_reg <= sk_reg - 5'd1;
                end
                S_TL_MUL:
                    state_reg <= S_TL_ACC;
                S_TL_ACC:
                begin
                    acc_reg <= pfirst_reg ? term : acc_reg + term;
                    if (tp_reg == 3'd0 || tp_reg == 3'd4)
                    begin
                        tp_reg    <= tp_reg + 3'd1;
                        state_reg <= S_TL_MUL;
                    end
                    else
                        state_reg <= S_TL_RND;
                end
                S_TL_RND:
                begin
                    case (tp_reg)
                        3'd1:
                        begin
                            t_reg     <= 35'((acc_u + 72'd134217728) >> 28);
                            tp_reg    <= 3'd2;
                            state_reg <= S_TL_MUL;
                        end
                        3'd2:
                        begin
                            if (a_full >= CUBE_LIMIT_Q16)
                            begin
                                tilt_reg  <= TILT_MAX;
                                state_reg <= S_FILT;
                            end
                            else
                            begin
                                ta_reg    <= a_full[26:0];
                                tp_reg    <= 3'd3;
                                state_reg <= S_TL_MUL;
                            end
                        end
                        3'd3:
                        begin
                            sq_reg    <= acc_rh[53:16];
                            tp_reg    <= 3'd4;
                            state_reg <= S_TL_MUL;
                        end
                        default:
                        begin
                            tilt_reg  <= (cube_full > 56'(TILT_MAX)) ? TILT_MAX
                                                                     : cube_full[47:0];
                            state_reg <= S_FILT;
                        end
                    endcase
                end
                S_FILT:
                begin
                    fup_reg   <= (tilt_reg > filt_reg);
                    fstep_reg <= (tilt_reg > filt_reg) ? tilt_reg - filt_reg
                                                       : filt_reg - tilt_reg;
                    state_reg <= S_FILT_APPLY;
                end
                S_FILT_APPLY:
                begin
                    if (fup_reg)
                        filt_reg <= filt_reg + ((fstep_reg > rise_limit_reg) ? rise_limit_reg
                                                                             : fstep_reg);
                    else
                        filt_reg <= filt_reg - ((fstep_reg > fall_limit_reg) ? fall_limit_reg
                                                                             : fstep_reg);
                    state_reg <= S_SLOPE;
                end
                S_SLOPE:
                begin
                    if (filt_reg <= slope_threshold_reg)
                        slope_cnt_reg <= '0;
                    else if (slope_cnt_reg != CNT_MAX)
                        slope_cnt_reg <= slope_cnt_reg + 17'd1;
                    av_reg    <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // Hold until the output register is free
                    if (out_load)
                    begin
                        out_av_reg    <= av_reg;
                        out_cal_reg   <= calib_reg;
                        out_yaw_reg   <= av_reg ? yaw_reg : '0;
                        out_slope_reg <= av_reg && (slope_cnt_reg > {1'b0, slope_ticks_reg});
                        for (int i = 0; i < 4; i++)
                            out_o_reg[i] <= o_reg[i];
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_av_reg;
    assign m_tdata  = {6'd0, out_o_reg[3], out_o_reg[2], out_o_reg[1], out_o_reg[0],
                       out_slope_reg, out_yaw_reg, out_cal_reg};

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            still_eps_w_reg     <= STILL_EPS_W_RST;
            still_eps_v_reg     <= STILL_EPS_V_RST;
            calib_ticks_reg     <= CALIB_TICKS_RST;
            slope_threshold_reg <= SLOPE_THRESHOLD_RST;
            slope_ticks_reg     <= SLOPE_TICKS_RST;
            rise_limit_reg      <= RISE_LIMIT_RST;
            fall_limit_reg      <= FALL_LIMIT_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_index_t'(paddr[5:3]))
                REG_STILL_EPS_W:     still_eps_w_reg     <= pwdata[30:0];
                REG_STILL_EPS_V:     still_eps_v_reg     <= pwdata[30:0];
                REG_CALIB_TICKS:     calib_ticks_reg     <= pwdata[15:0];
                REG_SLOPE_THRESHOLD: slope_threshold_reg <= pwdata[47:0];
                REG_SLOPE_TICKS:     slope_ticks_reg     <= pwdata[15:0];
                REG_RISE_LIMIT:      rise_limit_reg      <= pwdata[47:0];
                REG_FALL_LIMIT:      fall_limit_reg      <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_index_t'(paddr[5:3]))
            REG_STILL_EPS_W:     prdata = {33'd0, still_eps_w_reg};
            REG_STILL_EPS_V:     prdata = {33'd0, still_eps_v_reg};
            REG_CALIB_TICKS:     prdata = {48'd0, calib_ticks_reg};
            REG_SLOPE_THRESHOLD: prdata = {16'd0, slope_threshold_reg};
            REG_SLOPE_TICKS:     prdata = {48'd0, slope_ticks_reg};
            REG_RISE_LIMIT:      prdata = {16'd0, rise_limit_reg};
            REG_FALL_LIMIT:      prdata = {16'd0, fall_limit_reg};
            default:             prdata = '0;
        endcase
    end

    // Valid angles only come with a stored reference
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata[0])
        else $error("angles marked valid while uncalibrated");

    // Once set, the calibrated flag stays set
    assert property (@(posedge clk) disable iff (!rst_n) !$fell(calib_reg))
        else $error("calibrated flag dropped");

    // A loaded result leaves the sequencer idle with the output full
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result load did not return to idle");

    // Upward filter step never exceeds the rise limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILT_APPLY && fup_reg)
        |=> ((filt_reg - $past(filt_reg)) <= $past(rise_limit_reg)))
        else $error("filter rose faster than the rise limit");

    // Square root of 1 - s^2 stays within one in Q30
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CD_INIT && asel_reg != SEL_YAW) |-> (sr_reg <= 63'd1073741824))
        else $error("cosine term out of range");

endmodule

`default_nettype wire
